FILE: rtl/core/rgb_to_cmyk_pixel_defines.svh
// Assertion macros for the port checker of the RGB to CMYK converter.
`ifndef RGB_TO_CMYK_PIXEL_DEFINES_SVH
`define RGB_TO_CMYK_PIXEL_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define RGBCMYK_CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_cmyk_pixel port check failed");

// Condition that must hold at every rising clock edge outside reset.
`define RGBCMYK_CHK_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rgb_to_cmyk_pixel port check failed");

`endif

FILE: rtl/core/rgbcmyk_pkg.sv
// Shared types and constants of the RGB to CMYK converter.
package rgbcmyk_pkg;

    // Channel width and the full-scale level.
    localparam int unsigned ChanW     = 8;
    localparam int unsigned FullLevel = 255;

    // Numerator 510*(M-c)+M needs 17 bits; twice the maximum needs 9.
    localparam int unsigned NumW   = 17;
    localparam int unsigned DivW   = ChanW + 1;

    // Reciprocal floor(2^RecipShift / (2*M)) fits in 17 bits (M = 1 gives 2^16).
    localparam int unsigned RecipShift = 17;
    localparam int unsigned RecipW     = 17;
    localparam int unsigned RecipNum   = 1 << (RecipShift - 1);
    localparam int unsigned ProdW      = NumW + RecipW;

    // Number of entries in the reciprocal table, one per value of M.
    localparam int unsigned RecipDepth = 1 << ChanW;

    // Pipeline latency from an accepted beat to its result strobe.
    localparam int unsigned Latency = 3;

    // Stage enables handed to each separation lane.
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } sep_ctrl_t;

endpackage

FILE: rtl/core/rgbcmyk_sep_lane.sv
// One separation lane: reciprocal multiply, remainder correction and level inversion.
module rgbcmyk_sep_lane (
    input  logic                             clk,
    input  rgbcmyk_pkg::sep_ctrl_t           ctrl,
    input  logic [rgbcmyk_pkg::NumW-1:0]     num,
    input  logic [rgbcmyk_pkg::RecipW-1:0]   recip,
    input  logic [rgbcmyk_pkg::DivW-1:0]     divisor,
    input  logic                             zero,
    output logic [rgbcmyk_pkg::ChanW-1:0]    level
);
    import rgbcmyk_pkg::*;

    logic [ProdW-1:0]  prod;
    logic [ChanW-1:0]  q0_reg;
    logic [ChanW-1:0]  q0_next;
    logic [NumW-1:0]   num_reg;
    logic [DivW-1:0]   div_reg;
    logic              zero_reg;
    logic [NumW-1:0]   back_prod;
    logic [NumW-1:0]   rem;
    logic [ChanW-1:0]  quot;
    logic [ChanW-1:0]  level_reg;
    logic [ChanW-1:0]  level_next;

    // Estimate of the quotient: never above the true value and at most one below.
    assign prod    = ProdW'(num) * ProdW'(recip);
    assign q0_next = prod[RecipShift +: ChanW];

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_valid)
        begin
            q0_reg   <= q0_next;
            num_reg  <= num;
            div_reg  <= divisor;
            zero_reg <= zero;
        end
    end

    // Remainder check lifts the estimate by one where it fell short.
    assign back_prod = NumW'(q0_reg) * NumW'(div_reg);
    assign rem       = num_reg - back_prod;

    always_comb
    begin
        if (rem >= NumW'(div_reg))
        begin
            quot = q0_reg + ChanW'(1);
        end
        else
        begin
            quot = q0_reg;
        end
        if (zero_reg)
        begin
            level_next = ChanW'(FullLevel);
        end
        else
        begin
            level_next = ChanW'(FullLevel) - quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_valid)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

FILE: rtl/core/rgb_to_cmyk_pixel.sv
// Top level of the RGB to CMYK converter: maximum, reciprocal lookup and result stage.
//
//  Channel   Handshake        Fields
//  --------  ---------------  ------------------------------------------------------
//  pixel in  start / busy     red, green, blue, alpha_in
//  result    done (strobe)    cyan_level, magenta_level, yellow_level, black_level,
//                             alpha_out
//
// One beat is accepted every cycle; busy is never raised.
// A result strobes on done once its valid bit has passed through v1_reg, v2_reg and v3_reg.
// Stage one finds the maximum and reads the reciprocal table, stage two multiplies
// by the reciprocal, stage three corrects the quotient and inverts it.
// Reset clears the stage valid bits, so no stale result strobes after reset.
// The receiver takes every result in the cycle it is shown; nothing stalls.
module rgb_to_cmyk_pixel (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  red,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  green,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  blue,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  alpha_in,
    output logic                           done,
    output logic [rgbcmyk_pkg::ChanW-1:0]  cyan_level,
    output logic [rgbcmyk_pkg::ChanW-1:0]  magenta_level,
    output logic [rgbcmyk_pkg::ChanW-1:0]  yellow_level,
    output logic [rgbcmyk_pkg::ChanW-1:0]  black_level,
    output logic [rgbcmyk_pkg::ChanW-1:0]  alpha_out
);
    import rgbcmyk_pkg::*;

    logic                accept;
    logic [ChanW-1:0]    max_rg;
    logic [ChanW-1:0]    max_next;
    logic [ChanW-1:0]    chan [3];
    logic [NumW-1:0]     num_next [3];
    logic [RecipW-1:0]   recip_table [RecipDepth];

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic [ChanW-1:0]    max1_reg;
    logic [ChanW-1:0]    max2_reg;
    logic [ChanW-1:0]    max3_reg;
    logic [ChanW-1:0]    alpha1_reg;
    logic [ChanW-1:0]    alpha2_reg;
    logic [ChanW-1:0]    alpha3_reg;
    logic [NumW-1:0]     num1_reg [3];
    logic [RecipW-1:0]   recip1_reg;
    logic [ChanW-1:0]    level [3];
    sep_ctrl_t           lane_ctrl;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Reciprocal table: floor(2^17 / (2*M)); the entry for zero is never used.
    for (genvar i = 0; i < RecipDepth; i++)
    begin : g_recip
        localparam int unsigned RecipVal = (i == 0) ? 0 : RecipNum / ((i == 0) ? 1 : i);
        assign recip_table[i] = RecipW'(RecipVal);
    end

    // Largest of the three colour channels.
    assign max_rg   = (green > red) ? green : red;
    assign max_next = (blue > max_rg) ? blue : max_rg;

    // Numerators 510*(M-c) + M, which give the rounded quotient once halved by 2M.
    assign chan[0] = red;
    assign chan[1] = green;
    assign chan[2] = blue;

    for (genvar c = 0; c < 3; c++)
    begin : g_num
        logic [ChanW-1:0] diff;
        assign diff        = max_next - chan[c];
        assign num_next[c] = NumW'({diff, 9'd0}) - NumW'({diff, 1'b0}) + NumW'(max_next);
    end

    // Valid bits travel with the beat through the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            max1_reg    <= max_next;
            alpha1_reg  <= alpha_in;
            recip1_reg  <= recip_table[max_next];
            num1_reg[0] <= num_next[0];
            num1_reg[1] <= num_next[1];
            num1_reg[2] <= num_next[2];
        end
    end

    // Black and alpha ride alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            max2_reg   <= max1_reg;
            alpha2_reg <= alpha1_reg;
        end
        if (v2_reg)
        begin
            max3_reg   <= max2_reg;
            alpha3_reg <= alpha2_reg;
        end
    end

    assign lane_ctrl.s1_valid = v1_reg;
    assign lane_ctrl.s2_valid = v2_reg;

    // One divide lane per colour separation.
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        rgbcmyk_sep_lane u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .num     (num1_reg[c]),
            .recip   (recip1_reg),
            .divisor ({max1_reg, 1'b0}),
            .zero    (max1_reg == '0),
            .level   (level[c])
        );
    end

    assign done          = v3_reg;
    assign cyan_level    = level[0];
    assign magenta_level = level[1];
    assign yellow_level  = level[2];
    assign black_level   = max3_reg;
    assign alpha_out     = alpha3_reg;

endmodule

FILE: rtl/core/rgbcmyk_chk.sv
// Port checker for the RGB to CMYK converter, bound to the top level.
`include "rgb_to_cmyk_pixel_defines.svh"

module rgbcmyk_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  alpha_in,
    input  logic                           done,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  cyan_level,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  magenta_level,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  yellow_level,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  black_level,
    input  logic [rgbcmyk_pkg::ChanW-1:0]  alpha_out
);
    import rgbcmyk_pkg::*;

    // The pipeline never refuses a beat.
    `RGBCMYK_CHK_ALWAYS(a_never_busy, !busy)

    // Every accepted beat is followed by its result strobe on done.
    `RGBCMYK_CHK_IMPL(a_result_follows, start && !busy, ##3 done)

    // Alpha of a result is the alpha of the beat that produced it.
    `RGBCMYK_CHK_IMPL(a_alpha_kept, done, alpha_out == $past(alpha_in, 3))

    // The channel equal to the maximum always gives a full level.
    `RGBCMYK_CHK_IMPL(a_max_full, done,
        cyan_level == 8'hFF || magenta_level == 8'hFF || yellow_level == 8'hFF)

    // A black pixel gives full cyan, magenta and yellow levels.
    `RGBCMYK_CHK_IMPL(a_black_pixel, done && black_level == '0,
        cyan_level == 8'hFF && magenta_level == 8'hFF && yellow_level == 8'hFF)

endmodule

bind rgb_to_cmyk_pixel rgbcmyk_chk u_rgbcmyk_chk (.*);

FILE: bench/rgb_to_cmyk_pixel_test.sv
// Self-checking bench for the RGB to CMYK pixel converter: directed and random pixels.
`timescale 1ns / 100ps

module rgb_to_cmyk_pixel_test;
    import rgbcmyk_pkg::*;

    typedef logic [ChanW-1:0] chan_t;

    // Levels that one pixel must produce on the result ports.
    typedef struct {
        chan_t cyan;
        chan_t magenta;
        chan_t yellow;
        chan_t black;
        chan_t alpha;
    } cmyk_levels_t;

    // Works out the separations of each accepted pixel and checks them in order.
    class cmyk_ledger;
        cmyk_levels_t pending_cmyk[$];
        int unsigned  bad_fields;

        // One separation: full level less the rounded share of the channel's distance
        // from the peak, halves going up; a black pixel gives full level.
        function chan_t separation_level(chan_t peak, chan_t level);
            int unsigned numer;
            int unsigned quot;
            if (peak == 0)
                return chan_t'(FullLevel);
            numer = 2 * FullLevel * (int'(peak) - int'(level)) + peak;
            quot  = numer / (2 * int'(peak));
            if (quot > FullLevel)
                quot = FullLevel;
            return chan_t'(FullLevel - quot);
        endfunction

        function void note_pixel(chan_t r, chan_t g, chan_t b, chan_t a);
            cmyk_levels_t lv;
            chan_t        peak;
            peak = r;
            if (g > peak)
                peak = g;
            if (b > peak)
                peak = b;
            lv.cyan    = separation_level(peak, r);
            lv.magenta = separation_level(peak, g);
            lv.yellow  = separation_level(peak, b);
            lv.black   = peak;
            lv.alpha   = a;
            pending_cmyk.push_back(lv);
        endfunction

        function void compare_level(string label, chan_t want, chan_t got);
            if (got !== want)
            begin
                bad_fields++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void check_separations(chan_t c, chan_t m, chan_t y, chan_t k, chan_t a);
            cmyk_levels_t lv;
            if (pending_cmyk.size() == 0)
            begin
                bad_fields++;
                $display("%0t: result with no pixel outstanding, expected none, %s %0d %0d %0d %0d %0d",
                         $time, "actual", c, m, y, k, a);
                return;
            end
            lv = pending_cmyk.pop_front();
            compare_level("cyan_level", lv.cyan, c);
            compare_level("magenta_level", lv.magenta, m);
            compare_level("yellow_level", lv.yellow, y);
            compare_level("black_level", lv.black, k);
            compare_level("alpha_out", lv.alpha, a);
        endfunction
    endclass

    localparam int unsigned IdleLimit   = 2000;
    localparam int unsigned RandomBeats = 1500;

    logic  clk      = 1'b0;
    logic  rst_n    = 1'b0;
    logic  start    = 1'b0;
    chan_t red      = '0;
    chan_t green    = '0;
    chan_t blue     = '0;
    chan_t alpha_in = '0;
    logic  busy;
    logic  done;
    chan_t cyan_level;
    chan_t magenta_level;
    chan_t yellow_level;
    chan_t black_level;
    chan_t alpha_out;

    cmyk_ledger  ledger = new();
    int unsigned idle_cycles = 0;

    rgb_to_cmyk_pixel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha_in      (alpha_in),
        .done          (done),
        .cyan_level    (cyan_level),
        .magenta_level (magenta_level),
        .yellow_level  (yellow_level),
        .black_level   (black_level),
        .alpha_out     (alpha_out)
    );

    always #10 clk = ~clk;

    // Record every pixel beat that the block takes.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            ledger.note_pixel(red, green, blue, alpha_in);
    end

    // Check every result beat against the oldest outstanding pixel.
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_separations(cyan_level, magenta_level, yellow_level,
                                     black_level, alpha_out);
    end

    // Watchdog: give up after a long stretch with no beat moving either way.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one pixel after an optional gap and hold it until it is taken.
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                              input chan_t a, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        alpha_in <= a;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold the sender off until every outstanding pixel has produced its result.
    task automatic drain_pixels();
        start <= 1'b0;
        while (ledger.pending_cmyk.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        chan_t       r, g, b, a;
        bit          burst;
        int unsigned gap;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels: black, white, single primaries, the smallest peak,
        // ties that round upwards, greys and alpha extremes.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1);
        send_pixel(8'd255, 8'd0, 8'd0, 8'hAA, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'h55, 2);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd1, 0);
        send_pixel(8'd0, 8'd1, 8'd1, 8'd128, 3);
        send_pixel(8'd1, 8'd1, 8'd1, 8'd127, 0);
        send_pixel(8'd2, 8'd1, 8'd0, 8'd254, 0);
        send_pixel(8'd254, 8'd127, 8'd0, 8'd3, 7);
        send_pixel(8'd0, 8'd127, 8'd254, 8'hF0, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 8'h0F, 0);
        send_pixel(8'd255, 8'd254, 8'd1, 8'hAA, 0);
        send_pixel(8'd85, 8'd170, 8'd255, 8'h55, 4);
        send_pixel(8'd170, 8'd85, 8'd0, 8'hFF, 0);
        send_pixel(8'd3, 8'd2, 8'd1, 8'd0, 0);
        send_pixel(8'd200, 8'd200, 8'd100, 8'd77, 0);
        drain_pixels();

        // Random pixels in bursts and in gapped stretches.
        burst = 1'b0;
        for (int unsigned n = 0; n < RandomBeats; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            if (n == RandomBeats / 2)
                drain_pixels();
            r = chan_t'($urandom_range(0, 255));
            g = chan_t'($urandom_range(0, 255));
            b = chan_t'($urandom_range(0, 255));
            a = chan_t'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:
                begin
                    // Tiny peaks, where rounding is coarsest.
                    r = chan_t'($urandom_range(0, 3));
                    g = chan_t'($urandom_range(0, 3));
                    b = chan_t'($urandom_range(0, 3));
                end
                1:
                begin
                    // Grey pixels, or pixels with green equal to red.
                    g = r;
                    if ($urandom_range(0, 1) == 1)
                        b = r;
                end
                2:
                begin
                    // One channel at full scale.
                    case ($urandom_range(0, 2))
                        0: r = 8'd255;
                        1: g = 8'd255;
                        default: b = 8'd255;
                    endcase
                end
                default: ;
            endcase
            gap = burst ? 0 : $urandom_range(0, 7);
            send_pixel(r, g, b, a, gap);
        end

        // Let the pipeline empty and give any stray strobe time to show.
        drain_pixels();
        repeat (Latency + 4) @(posedge clk);
        if (ledger.bad_fields == 0 && ledger.pending_cmyk.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
